FILE: sv/lgge_pkg.sv
// shared types, codes and the life rule for the life grid generation engine
`default_nettype none

package lgge_pkg;

   // transaction op codes
   localparam logic [1:0] OP_WRITE_CELL = 2'd0;
   localparam logic [1:0] OP_READ_CELL  = 2'd1;
   localparam logic [1:0] OP_GENERATION = 2'd2;

   // configuration register indexes
   localparam logic CSR_ACTIVE_COLUMNS = 1'b0;
   localparam logic CSR_ACTIVE_ROWS    = 1'b1;

   // neighbour counts of the b3/s23 rule
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CELL   = 7'b0000100,
      ST_GEN0   = 7'b0001000,
      ST_GEN1   = 7'b0010000,
      ST_SWEEP  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   function automatic logic next_cell(input logic old, input logic [3:0] count);
      next_cell = (count == BIRTH_COUNT) || (old && (count == SURVIVE_COUNT));
   endfunction

endpackage

`default_nettype wire

FILE: sv/lgge_ram.sv
// generic single write port ram with one registered read port
`default_nettype none

module lgge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

FILE: sv/lgge_row_rule.sv
// next generation of one row from the masked rows above, at and below it
`default_nettype none

module lgge_row_rule #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] up_row,
   input  wire logic [WIDTH-1:0] mid_row,
   input  wire logic [WIDTH-1:0] down_row,
   output logic      [WIDTH-1:0] next_row
);

   always_comb begin
      logic [3:0] count;
      for (int c = 0; c < WIDTH; c++) begin
         count = {3'd0, up_row[c]} + {3'd0, down_row[c]};
         if (c > 0) begin
            count = count + {3'd0, up_row[c-1]} + {3'd0, mid_row[c-1]}
                    + {3'd0, down_row[c-1]};
         end
         if (c < WIDTH - 1) begin
            count = count + {3'd0, up_row[c+1]} + {3'd0, mid_row[c+1]}
                    + {3'd0, down_row[c+1]};
         end
         next_row[c] = lgge_pkg::next_cell(mid_row[c], count);
      end
   end

endmodule

`default_nettype wire

FILE: sv/life_grid_generation_engine.sv
// life grid generation engine: b3/s23 cell grid with cell access and generation steps
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_op, req_column, req_row, req_alive_in
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_cell_state, rsp_step_done
//   csr     | in        | csr_write_en           | csr_index, csr_data
//
// cell write and cell read: from accept to result, the row arrives and is modified (ST_CELL), then finish
// generation: ST_GEN0 and ST_GEN1 fetch row 0, then one row a cycle through the three-row window
// the row memory's single read port sets that sweep rate: one row fetched per cycle
// after reset a clearing pass over all MAX_ROWS rows zeroes the grid; no req accepted meanwhile
// one transaction at a time; a new one is accepted while the last result waits on rsp_stall
`default_nettype none

module life_grid_generation_engine #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [5:0] req_column,
   input  wire logic [5:0] req_row,
   input  wire logic       req_alive_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_cell_state,
   output logic            rsp_step_done,
   input  wire logic       csr_write_en,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_data
);

   // widths
   localparam int RW  = $clog2(MAX_ROWS);       // row address
   localparam int CIW = $clog2(MAX_COLUMNS);    // column index inside a row
   localparam int CCW = ($clog2(MAX_COLUMNS + 1) > 7) ? $clog2(MAX_COLUMNS + 1) : 7;
   localparam int RCW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;

   // configuration registers
   logic [6:0] active_columns_ff, active_columns_in;
   logic [6:0] active_rows_ff, active_rows_in;

   // control
   lgge_pkg::state_type state_ff, state_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;

   // latched transaction
   logic [1:0] op_ff, op_in;
   logic [5:0] col_ff, col_in;
   logic [5:0] row_ff, row_in;
   logic       alive_ff, alive_in;

   // pending result and output register
   logic res_cell_ff, res_cell_in;
   logic res_done_ff, res_done_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_cell_ff, rsp_cell_in;
   logic rsp_done_ff, rsp_done_in;

   // three-row window: raw rows, the row below comes straight from the memory
   logic [MAX_COLUMNS-1:0] up_raw_ff, up_raw_in;
   logic [MAX_COLUMNS-1:0] mid_raw_ff, mid_raw_in;
   logic                   up_ok_ff, up_ok_in;

   // memory port
   logic                   mem_we;
   logic [RW-1:0]          mem_waddr;
   logic [MAX_COLUMNS-1:0] mem_wdata;
   logic [RW-1:0]          mem_raddr;
   logic [MAX_COLUMNS-1:0] mem_rdata;

   // derived area, clamped to 1..max
   logic [CCW-1:0]         cols_eff;
   logic [RCW-1:0]         rows_eff;
   logic [MAX_COLUMNS-1:0] col_mask;
   logic                   in_area;
   logic [RCW:0]           row_next;
   logic                   down_ok;
   logic                   req_accept;
   logic                   rsp_free;

   // masked window and next row
   logic [MAX_COLUMNS-1:0] up_row, mid_row, down_row, next_row;

   lgge_ram #(
      .WIDTH(MAX_COLUMNS),
      .DEPTH(MAX_ROWS)
   ) u_grid_ram (
      .clock      (clock),
      .write_en   (mem_we),
      .write_addr (mem_waddr),
      .write_data (mem_wdata),
      .read_addr  (mem_raddr),
      .read_data  (mem_rdata)
   );

   lgge_row_rule #(
      .WIDTH(MAX_COLUMNS)
   ) u_row_rule (
      .up_row   (up_row),
      .mid_row  (mid_row),
      .down_row (down_row),
      .next_row (next_row)
   );

   // area clamp: zero reads as one, anything above the maximum as the maximum
   always_comb begin
      if (active_columns_ff == 7'd0) begin
         cols_eff = CCW'(1);
      end else if (CCW'(active_columns_ff) > CCW'(MAX_COLUMNS)) begin
         cols_eff = CCW'(MAX_COLUMNS);
      end else begin
         cols_eff = CCW'(active_columns_ff);
      end
      if (active_rows_ff == 7'd0) begin
         rows_eff = RCW'(1);
      end else if (RCW'(active_rows_ff) > RCW'(MAX_ROWS)) begin
         rows_eff = RCW'(MAX_ROWS);
      end else begin
         rows_eff = RCW'(active_rows_ff);
      end
   end

   // columns in use
   always_comb begin
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         col_mask[c] = (CCW'(c) < cols_eff);
      end
   end

   assign in_area  = (CCW'(col_ff) < cols_eff) && (RCW'(row_ff) < rows_eff);
   assign row_next = (RCW + 1)'(row_cnt_ff) + (RCW + 1)'(1);
   assign down_ok  = (row_next < {1'b0, rows_eff});

   // dead boundary: rows and columns outside the active area count as dead
   assign up_row   = up_ok_ff ? (up_raw_ff & col_mask) : '0;
   assign mid_row  = mid_raw_ff & col_mask;
   assign down_row = down_ok ? (mem_rdata & col_mask) : '0;

   assign req_stall  = (state_ff != lgge_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_comb begin
      active_columns_in = active_columns_ff;
      active_rows_in    = active_rows_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            lgge_pkg::CSR_ACTIVE_COLUMNS: active_columns_in = csr_data;
            lgge_pkg::CSR_ACTIVE_ROWS:    active_rows_in    = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer and memory access
   always_comb begin
      state_in    = state_ff;
      row_cnt_in  = row_cnt_ff;
      op_in       = op_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      alive_in    = alive_ff;
      res_cell_in = res_cell_ff;
      res_done_in = res_done_ff;
      up_raw_in   = up_raw_ff;
      mid_raw_in  = mid_raw_ff;
      up_ok_in    = up_ok_ff;
      mem_we      = 1'b0;
      mem_waddr   = row_cnt_ff;
      mem_wdata   = '0;
      mem_raddr   = row_cnt_ff;

      unique case (state_ff)
         lgge_pkg::ST_CLEAR: begin
            // zero one row a cycle
            mem_we = 1'b1;
            if (row_cnt_ff == RW'(MAX_ROWS - 1)) begin
               state_in   = lgge_pkg::ST_IDLE;
               row_cnt_in = '0;
            end else begin
               row_cnt_in = row_cnt_ff + RW'(1);
            end
         end
         lgge_pkg::ST_IDLE: begin
            // fetch the addressed row right away
            mem_raddr = RW'(req_row);
            if (req_accept) begin
               op_in       = req_op;
               col_in      = req_column;
               row_in      = req_row;
               alive_in    = req_alive_in;
               res_cell_in = 1'b0;
               res_done_in = 1'b0;
               unique case (req_op) inside
                  lgge_pkg::OP_WRITE_CELL,
                  lgge_pkg::OP_READ_CELL:  state_in = lgge_pkg::ST_CELL;
                  lgge_pkg::OP_GENERATION: state_in = lgge_pkg::ST_GEN0;
                  default:                 state_in = lgge_pkg::ST_FINISH;
               endcase
            end
         end
         lgge_pkg::ST_CELL: begin
            // row read back: modify one bit or pick one bit
            mem_waddr = RW'(row_ff);
            mem_wdata = mem_rdata;
            mem_wdata[CIW'(col_ff)] = alive_ff;
            if (op_ff == lgge_pkg::OP_WRITE_CELL) begin
               mem_we = in_area;
            end else begin
               res_cell_in = in_area && mem_rdata[CIW'(col_ff)];
            end
            state_in = lgge_pkg::ST_FINISH;
         end
         lgge_pkg::ST_GEN0: begin
            mem_raddr = '0;
            state_in  = lgge_pkg::ST_GEN1;
         end
         lgge_pkg::ST_GEN1: begin
            // row 0 arrives; nothing lies above it
            mem_raddr  = RW'(1);
            mid_raw_in = mem_rdata;
            up_ok_in   = 1'b0;
            row_cnt_in = '0;
            state_in   = lgge_pkg::ST_SWEEP;
         end
         lgge_pkg::ST_SWEEP: begin
            // row r+1 arrives, row r is written, row r+2 is fetched
            mem_raddr  = RW'(row_next + (RCW + 1)'(1));
            mem_we     = 1'b1;
            mem_waddr  = row_cnt_ff;
            mem_wdata  = (next_row & col_mask) | (mid_raw_ff & ~col_mask);
            up_raw_in  = mid_raw_ff;
            up_ok_in   = 1'b1;
            mid_raw_in = mem_rdata;
            if (!down_ok) begin
               res_done_in = 1'b1;
               state_in    = lgge_pkg::ST_FINISH;
            end else begin
               row_cnt_in = row_cnt_ff + RW'(1);
            end
         end
         lgge_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = lgge_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lgge_pkg::ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cell_in  = rsp_cell_ff;
      rsp_done_in  = rsp_done_ff;
      if ((state_ff == lgge_pkg::ST_FINISH) && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_cell_in  = res_cell_ff;
         rsp_done_in  = res_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= lgge_pkg::ST_CLEAR;
         row_cnt_ff        <= '0;
         active_columns_ff <= 7'd64;
         active_rows_ff    <= 7'd64;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         row_cnt_ff        <= row_cnt_in;
         active_columns_ff <= active_columns_in;
         active_rows_ff    <= active_rows_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      alive_ff    <= alive_in;
      res_cell_ff <= res_cell_in;
      res_done_ff <= res_done_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_done_ff <= rsp_done_in;
      up_raw_ff   <= up_raw_in;
      mid_raw_ff  <= mid_raw_in;
      up_ok_ff    <= up_ok_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_state = rsp_cell_ff;
   assign rsp_step_done  = rsp_done_ff;

   // a result never reports a cell value and a finished step at once
   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cell_state && rsp_step_done))
      else $error("result carries both cell state and step done");

   // the grid is only written by the clear pass, a cell write or a sweep
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgge_pkg::ST_IDLE) || (state_ff == lgge_pkg::ST_FINISH)
      || (state_ff == lgge_pkg::ST_GEN0) || (state_ff == lgge_pkg::ST_GEN1) |-> !mem_we)
      else $error("grid written outside a write phase");

   // the sweep never goes past the active rows
   a_sweep_in_area: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgge_pkg::ST_SWEEP) |-> (RCW'(row_cnt_ff) < rows_eff))
      else $error("sweep row beyond active area");

   // an accepted transaction always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != lgge_pkg::ST_IDLE))
      else $error("accepted transaction not started");

   // a finished generation always reports step done
   a_step_reported: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lgge_pkg::ST_SWEEP) && !down_ok |=> res_done_ff)
      else $error("generation finished without step done");

endmodule

`default_nettype wire
